[rtl/lkod_pkg.sv]
// Shared types and defaults for the lock-order cycle detector.
package lkod_pkg;

  localparam int NUM_LOCKS_DEF   = 32;
  localparam int NUM_THREADS_DEF = 8;
  localparam int HELD_DEPTH_DEF  = 8;

  localparam int LOCK_ID_W   = 5;
  localparam int THREAD_ID_W = 3;

  localparam logic MODE_ACQUIRE = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ASCAN,
    ST_LINK,
    ST_PEEL,
    ST_RSCAN,
    ST_SHIFT,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic link;
    logic peel_init;
    logic peel_step;
  } graph_cmd_t;

  typedef struct packed {
    logic settled;
    logic alive_any;
  } graph_stat_t;

endpackage

[rtl/lock_order_cycle_detector_core.sv]
// Lock-order cycle detector top level: event sequencer, held stacks and result beat.
// Acquire: scan the thread's held stack, link the new edges and run peel passes until the live
//   set settles (skipped once a cycle is latched), then strobe done in the result beat.
// Release: scan the stack from the top, shift the entries above a hit down, then strobe done;
//   out-of-range events go straight to the result beat. One event at a time: busy holds from
//   the accept through the result beat, so the next start is taken in the cycle after done at
//   the earliest. Synchronous reset clears the edge matrix, held counts (via valid bits) and cycle flag.
module lock_order_cycle_detector_core #(
  parameter int NUM_LOCKS   = lkod_pkg::NUM_LOCKS_DEF,
  parameter int NUM_THREADS = lkod_pkg::NUM_THREADS_DEF,
  parameter int HELD_DEPTH  = lkod_pkg::HELD_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             mode,
  input  logic [lkod_pkg::LOCK_ID_W-1:0]   lock_id,
  input  logic [lkod_pkg::THREAD_ID_W-1:0] thread_id,
  output logic                             done,
  output logic                             cycle_detected,
  output logic                             held_full,
  output logic                             not_held
);

  localparam int LW = $clog2(NUM_LOCKS);
  localparam int TW = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
  localparam int SW = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
  localparam int CW = $clog2(HELD_DEPTH + 1);
  localparam int AW = TW + SW;

  lkod_pkg::state_t state, state_next;

  // Event beat, latched at accept.
  logic          mode_q;
  logic [LW-1:0] lk;
  logic [TW-1:0] tid;
  logic [CW-1:0] cnt;

  // Scan and shift pointers.
  logic [CW-1:0] rp;
  logic [SW-1:0] wp;
  logic [SW-1:0] islot;
  logic          pend;
  logic [CW-1:0] rslot;
  logic          hit;

  logic [NUM_LOCKS-1:0] mask;
  logic                 res_cyc, res_full, res_miss;
  logic                 cycle_seen;

  // Held stacks: one row of HELD_DEPTH slots per thread.
  logic [LW-1:0] stack_mem [2**AW];
  logic [LW-1:0] rd_data;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [LW-1:0] wr_data;

  // Held counts with reset valid bits; an invalid entry reads as zero.
  logic [CW-1:0]     cnt_mem [2**TW];
  logic [2**TW-1:0]  cnt_vld;
  logic              cnt_we;
  logic [CW-1:0]     cnt_wdata;

  logic [TW-1:0] tid_in;
  logic [LW-1:0] lk_in;
  logic          in_range;
  logic          accept;

  lkod_pkg::graph_cmd_t  gcmd;
  lkod_pkg::graph_stat_t gstat;

  assign tid_in   = TW'(thread_id);
  assign lk_in    = LW'(lock_id);
  assign in_range = (int'(lock_id) < NUM_LOCKS) && (int'(thread_id) < NUM_THREADS);
  assign accept   = start && !busy;

  // Release scans from the top of the stack down.
  assign rslot = cnt - rp - CW'(1);
  assign hit   = (state == lkod_pkg::ST_RSCAN) && pend && (rd_data == lk);

  lkod_graph #(
    .NUM_LOCKS(NUM_LOCKS)
  ) u_graph (
    .clk (clk),
    .rst (rst),
    .cmd (gcmd),
    .mask(mask),
    .lk  (lk),
    .stat(gstat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lkod_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = {tid, rp[SW-1:0]};
    wr_en      = 1'b0;
    wr_addr    = {tid, wp};
    wr_data    = rd_data;
    cnt_we     = 1'b0;
    cnt_wdata  = cnt;
    gcmd       = '0;
    case (state)
      lkod_pkg::ST_IDLE: begin
        if (start) begin
          if (!in_range) begin
            state_next = lkod_pkg::ST_RESP;
          end else if (mode == lkod_pkg::MODE_RELEASE) begin
            state_next = lkod_pkg::ST_RSCAN;
          end else begin
            state_next = lkod_pkg::ST_ASCAN;
          end
        end
      end
      lkod_pkg::ST_ASCAN: begin
        // Walk every held slot; the registered read lands in the next cycle.
        if (rp < cnt) begin
          rd_en = 1'b1;
        end
        if ((rp == cnt) && !pend) begin
          state_next = lkod_pkg::ST_LINK;
        end
      end
      lkod_pkg::ST_LINK: begin
        gcmd.link      = 1'b1;
        gcmd.peel_init = 1'b1;
        if (int'(cnt) < HELD_DEPTH) begin
          wr_en     = 1'b1;
          wr_addr   = {tid, cnt[SW-1:0]};
          wr_data   = lk;
          cnt_we    = 1'b1;
          cnt_wdata = cnt + CW'(1);
        end
        // Edges only accumulate, so a latched cycle needs no new search.
        state_next = cycle_seen ? lkod_pkg::ST_RESP : lkod_pkg::ST_PEEL;
      end
      lkod_pkg::ST_PEEL: begin
        gcmd.peel_step = 1'b1;
        if (gstat.settled) begin
          state_next = lkod_pkg::ST_RESP;
        end
      end
      lkod_pkg::ST_RSCAN: begin
        rd_addr = {tid, rslot[SW-1:0]};
        if ((rp < cnt) && !hit) begin
          rd_en = 1'b1;
        end
        if (hit) begin
          state_next = lkod_pkg::ST_SHIFT;
        end else if ((rp == cnt) && !pend) begin
          state_next = lkod_pkg::ST_RESP;
        end
      end
      lkod_pkg::ST_SHIFT: begin
        // Close the gap: read slot rp, write it one slot lower next cycle.
        if (pend) begin
          wr_en = 1'b1;
        end
        if (rp < cnt) begin
          rd_en = 1'b1;
        end
        if ((rp == cnt) && !pend) begin
          cnt_we     = 1'b1;
          cnt_wdata  = cnt - CW'(1);
          state_next = lkod_pkg::ST_RESP;
        end
      end
      lkod_pkg::ST_RESP: begin
        state_next = lkod_pkg::ST_IDLE;
      end
      default: begin
        state_next = lkod_pkg::ST_IDLE;
      end
    endcase
  end

  // Event datapath.
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q   <= mode;
      lk       <= lk_in;
      tid      <= tid_in;
      cnt      <= cnt_vld[tid_in] ? cnt_mem[tid_in] : '0;
      rp       <= '0;
      wp       <= '0;
      pend     <= 1'b0;
      mask     <= '0;
      res_cyc  <= 1'b0;
      res_full <= 1'b0;
      res_miss <= 1'b0;
    end else begin
      if (hit) begin
        pend <= 1'b0;
        rp   <= CW'(islot) + CW'(1);
        wp   <= islot;
      end else begin
        pend <= rd_en;
        if (rd_en) begin
          rp <= rp + CW'(1);
        end
      end
      if (rd_en) begin
        islot <= rd_addr[SW-1:0];
      end
      if ((state == lkod_pkg::ST_SHIFT) && pend) begin
        wp <= wp + SW'(1);
      end
      // Collect every other held lock as an edge source.
      if ((state == lkod_pkg::ST_ASCAN) && pend && (rd_data != lk)) begin
        mask <= mask | (NUM_LOCKS'(1) << rd_data);
      end
      if (state == lkod_pkg::ST_LINK) begin
        res_full <= !(int'(cnt) < HELD_DEPTH);
        if (cycle_seen) begin
          res_cyc <= 1'b1;
        end
      end
      if ((state == lkod_pkg::ST_PEEL) && gstat.settled) begin
        res_cyc <= gstat.alive_any;
      end
      if ((state == lkod_pkg::ST_RSCAN) && !hit && (rp == cnt) && !pend) begin
        res_miss <= 1'b1;
      end
    end
  end

  // Sticky cycle flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_seen <= 1'b0;
    end else if ((state == lkod_pkg::ST_PEEL) && gstat.settled && gstat.alive_any) begin
      cycle_seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= stack_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[tid] <= cnt_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_vld <= '0;
    end else if (cnt_we) begin
      cnt_vld[tid] <= 1'b1;
    end
  end

  // Hold busy high through reset so no beat is taken while the state is cleared.
  assign busy           = rst || (state != lkod_pkg::ST_IDLE);
  assign done           = (state == lkod_pkg::ST_RESP);
  assign cycle_detected = res_cyc;
  assign held_full      = res_full;
  assign not_held       = res_miss;

  // Hold busy from the accepting edge on.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy did not rise after accept");

  // A release never reports acquire flags and vice versa.
  a_flag_mix: assert property (@(posedge clk) disable iff (rst)
    done |-> !(not_held && (cycle_detected || held_full)))
    else $error("release and acquire flags in one result beat");

  // Once latched, the cycle flag stays set.
  a_cycle_sticky: assert property (@(posedge clk) disable iff (rst)
    cycle_seen |=> cycle_seen)
    else $error("cycle flag dropped");

  // The peel search only runs while no cycle is latched.
  a_peel_skip: assert property (@(posedge clk) disable iff (rst)
    (state == lkod_pkg::ST_PEEL) |-> !cycle_seen)
    else $error("peel pass with a latched cycle");

  // A release result follows a release event.
  a_miss_mode: assert property (@(posedge clk) disable iff (rst)
    (done && not_held) |-> (mode_q == lkod_pkg::MODE_RELEASE))
    else $error("not_held on an acquire");

endmodule

[rtl/lkod_graph.sv]
// Lock-order edge matrix and the shared peel step that tests it for a cycle.
module lkod_graph #(
  parameter int NUM_LOCKS = lkod_pkg::NUM_LOCKS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lkod_pkg::graph_cmd_t         cmd,
  input  logic [NUM_LOCKS-1:0]         mask,
  input  logic [$clog2(NUM_LOCKS)-1:0] lk,
  output lkod_pkg::graph_stat_t        stat
);

  logic [NUM_LOCKS-1:0] edges [NUM_LOCKS];
  logic [NUM_LOCKS-1:0] alive;
  logic [NUM_LOCKS-1:0] alive_next;

  // A node survives a step only while it still points into the live set.
  always_comb begin
    for (int n = 0; n < NUM_LOCKS; n++) begin
      alive_next[n] = alive[n] & (|(edges[n] & alive));
    end
  end

  assign stat.settled   = (alive_next == alive);
  assign stat.alive_any = |alive;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NUM_LOCKS; r++) begin
        edges[r] <= '0;
      end
    end else if (cmd.link) begin
      for (int r = 0; r < NUM_LOCKS; r++) begin
        if (mask[r]) begin
          edges[r][lk] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.peel_init) begin
      alive <= '1;
    end else if (cmd.peel_step) begin
      alive <= alive_next;
    end
  end

endmodule

[tb/sv/lock_order_cycle_detector_core_tb.sv]
// Self-checking testbench for the lock-order cycle detector: scoreboard class and drivers.
module lock_order_cycle_detector_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NL  = lkod_pkg::NUM_LOCKS_DEF;
  localparam int NT  = lkod_pkg::NUM_THREADS_DEF;
  localparam int HD  = lkod_pkg::HELD_DEPTH_DEF;
  localparam int LKW = lkod_pkg::LOCK_ID_W;
  localparam int THW = lkod_pkg::THREAD_ID_W;

  // Worst correct run is near 1600 beats plus sender gaps; take it several times.
  localparam int RUN_LIMIT         = 400000;
  localparam int ORDERED_PER_PHASE = 345;
  localparam int TANGLED_EVENTS    = 200;
  localparam int DRAIN_CYCLES      = 80;
  localparam int MAX_REPORTS       = 10;

  // Predicts the result beat for each accepted event and checks the beats that come back.
  class lock_order_scoreboard;
    typedef struct packed {
      logic cyc;
      logic full;
      logic miss;
    } verdict_t;

    bit [NL-1:0]          order_edges [NL];
    bit [LKW-1:0]         held [NT][HD];
    int unsigned          depth [NT];
    bit                   cycle_latched;
    verdict_t             verdicts [$];
    int unsigned          mismatches;

    function new();
      foreach (order_edges[r]) order_edges[r] = '0;
      foreach (depth[t]) depth[t] = 0;
      cycle_latched = 1'b0;
      mismatches = 0;
    endfunction

    // Strip locks with no edge into the surviving set; survivors mean a loop.
    function bit order_has_loop();
      bit [NL-1:0] alive;
      bit          changed;
      alive = '1;
      changed = 1'b1;
      while (changed) begin
        changed = 1'b0;
        for (int n = 0; n < NL; n++) begin
          if (alive[n] && (order_edges[n] & alive) == '0) begin
            alive[n] = 1'b0;
            changed = 1'b1;
          end
        end
      end
      return alive != '0;
    endfunction

    function void note_event(logic m, logic [LKW-1:0] lk, logic [THW-1:0] th);
      verdict_t    v;
      int unsigned cnt;
      bit          found;
      v = '0;
      cnt = depth[th];
      if (m == lkod_pkg::MODE_ACQUIRE) begin
        for (int i = 0; i < cnt; i++)
          if (held[th][i] != lk) order_edges[held[th][i]][lk] = 1'b1;
        if (order_has_loop()) cycle_latched = 1'b1;
        v.cyc = cycle_latched;
        if (cnt < HD) begin
          held[th][cnt] = lk;
          depth[th] = cnt + 1;
        end else begin
          v.full = 1'b1;
        end
      end else begin
        found = 1'b0;
        // Remove the most recent entry and close the gap.
        for (int i = cnt - 1; i >= 0 && !found; i--) begin
          if (held[th][i] == lk) begin
            for (int k = i; k + 1 < cnt; k++) held[th][k] = held[th][k+1];
            depth[th] = cnt - 1;
            found = 1'b1;
          end
        end
        v.miss = !found;
      end
      verdicts.insert(verdicts.size(), v);
    endfunction

    function void check_result(logic cyc, logic full, logic miss);
      verdict_t want;
      if (verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] result beat with nothing expected: cyc=%b full=%b miss=%b",
                   $realtime, cyc, full, miss);
        return;
      end
      want = verdicts.pop_front();
      if (cyc !== want.cyc || full !== want.full || miss !== want.miss) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] mismatch: expected cyc=%b full=%b miss=%b, got cyc=%b full=%b miss=%b",
                   $realtime, want.cyc, want.full, want.miss, cyc, full, miss);
      end
    endfunction

    function int unsigned pending();
      return verdicts.size();
    endfunction
  endclass

  logic           clk;
  logic           rst;
  logic           start;
  logic           busy;
  logic           mode;
  logic [LKW-1:0] lock_id;
  logic [THW-1:0] thread_id;
  logic           done;
  logic           cycle_detected;
  logic           held_full;
  logic           not_held;

  lock_order_scoreboard sb = new();
  int unsigned          cycle_count = 0;
  int unsigned          idle_pct = 0;

  lock_order_cycle_detector_core #(
    .NUM_LOCKS   (NL),
    .NUM_THREADS (NT),
    .HELD_DEPTH  (HD)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .mode           (mode),
    .lock_id        (lock_id),
    .thread_id      (thread_id),
    .done           (done),
    .cycle_detected (cycle_detected),
    .held_full      (held_full),
    .not_held       (not_held)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hold one event on the inputs until the block takes it. Start is left high on return
  // so back-to-back beats never drop it; every waiting path lowers it first.
  task automatic send_event(input logic m, input int unsigned lk, input int unsigned th);
    logic [LKW-1:0] lk_b;
    logic [THW-1:0] th_b;
    lk_b = LKW'(lk);
    th_b = THW'(th);
    @(negedge clk);
    start     <= 1'b1;
    mode      <= m;
    lock_id   <= lk_b;
    thread_id <= th_b;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_event(m, lk_b, th_b);
  endtask

  // Idle the sender at random; scramble the fields while start is low.
  task automatic sender_gap();
    while ($urandom_range(99, 0) < idle_pct) begin
      @(negedge clk);
      start     <= 1'b0;
      mode      <= 1'($urandom_range(1, 0));
      lock_id   <= LKW'($urandom);
      thread_id <= THW'($urandom);
    end
  endtask

  // Drop start and hold off until every expected beat has come back.
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Well-formed traffic: acquire only above every lock the thread holds (or the top one
  // again), so all edges point upward and the graph stays free of loops.
  task automatic ordered_event();
    int unsigned th;
    int unsigned cnt;
    int          top;
    int          lk;
    int unsigned pick;
    th  = $urandom_range(NT - 1, 0);
    cnt = sb.depth[th];
    top = -1;
    for (int i = 0; i < cnt; i++)
      if (int'(sb.held[th][i]) > top) top = int'(sb.held[th][i]);
    pick = $urandom_range(99, 0);
    if (cnt == 0 || pick < 60) begin
      if (top >= 0 && (top == NL - 1 || $urandom_range(9, 0) == 0))
        lk = top;
      else
        lk = top + 1 + $urandom_range(((NL - 2 - top) < 4) ? (NL - 2 - top) : 4, 0);
      send_event(lkod_pkg::MODE_ACQUIRE, lk, th);
    end else if (pick < 92) begin
      send_event(lkod_pkg::MODE_RELEASE, 32'(sb.held[th][$urandom_range(cnt - 1, 0)]), th);
    end else begin
      send_event(lkod_pkg::MODE_RELEASE, $urandom_range(NL - 1, 0), th);
    end
  endtask

  // Unordered traffic: any lock in any order, so a loop forms and then stays.
  task automatic tangled_event();
    int unsigned th;
    int unsigned cnt;
    th  = $urandom_range(NT - 1, 0);
    cnt = sb.depth[th];
    if (cnt == 0 || $urandom_range(1, 0) == 0)
      send_event(lkod_pkg::MODE_ACQUIRE, $urandom_range(NL - 1, 0), th);
    else if ($urandom_range(9, 0) < 7)
      send_event(lkod_pkg::MODE_RELEASE, 32'(sb.held[th][$urandom_range(cnt - 1, 0)]), th);
    else
      send_event(lkod_pkg::MODE_RELEASE, $urandom_range(NL - 1, 0), th);
  endtask

  // Every done strobe is a result beat; the receiver cannot stall it.
  always @(posedge clk) begin
    if (!rst && done === 1'b1)
      sb.check_result(cycle_detected, held_full, not_held);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned phase_idle [4];
    phase_idle = '{0, 72, 0, 8};
    start     = 1'b0;
    mode      = lkod_pkg::MODE_ACQUIRE;
    lock_id   = '0;
    thread_id = '0;
    rst       = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: release on an empty list, reacquire of a held lock, extreme ids,
    // a list filled to the top and then overrun, release from the middle of a list.
    send_event(lkod_pkg::MODE_RELEASE, 5, 0);
    send_event(lkod_pkg::MODE_ACQUIRE, 0, 0);
    send_event(lkod_pkg::MODE_ACQUIRE, 0, 0);
    send_event(lkod_pkg::MODE_ACQUIRE, NL - 1, NT - 1);
    send_event(lkod_pkg::MODE_RELEASE, NL - 1, NT - 1);
    send_event(lkod_pkg::MODE_RELEASE, NL - 1, NT - 1);
    for (int l = 1; l <= HD; l++) send_event(lkod_pkg::MODE_ACQUIRE, l, 3);
    send_event(lkod_pkg::MODE_ACQUIRE, HD + 1, 3);
    send_event(lkod_pkg::MODE_RELEASE, 4, 3);
    send_event(lkod_pkg::MODE_RELEASE, HD + 1, 3);
    send_event(lkod_pkg::MODE_RELEASE, 0, 0);
    send_event(lkod_pkg::MODE_RELEASE, 0, 0);
    send_event(lkod_pkg::MODE_RELEASE, 0, 0);
    drain_results();

    // Loop-free phases under different sender idling, with occasional full drains.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = phase_idle[ph];
      for (int n = 0; n < ORDERED_PER_PHASE; n++) begin
        sender_gap();
        ordered_event();
        if ($urandom_range(49, 0) == 0) drain_results();
      end
      drain_results();
    end

    // Close with unordered traffic; the sticky loop flag must then hold on every acquire.
    idle_pct = 30;
    for (int n = 0; n < TANGLED_EVENTS; n++) begin
      sender_gap();
      tangled_event();
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
